FILE: hw/rtl/cau_pkg.sv
// Shared opcode type and default widths of the complex arithmetic unit.
package cau_pkg;

    localparam int CAU_WIDTH     = 32;
    localparam int CAU_FRAC_BITS = 16;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_NEG  = 4'd4,
        OP_CONJ = 4'd5,
        OP_ABS2 = 4'd6,
        OP_ABS  = 4'd7,
        OP_NORM = 4'd8,
        OP_INV  = 4'd9,
        OP_SQRT = 4'd10,
        OP_DOT  = 4'd11
    } op_t;

endpackage

FILE: hw/rtl/complex_arithmetic_unit.sv
// Deep pipelined fixed-point complex ALU: one word per cycle while it is not stalled.
//
// The unit takes one word per cycle and returns one result word per cycle while it is not
// stalled. With the default widths every word passes 65 register stages; the depth is
// set by the restoring divider (an overflow check
// and then one quotient bit per stage, 34 stages), which runs beside the square root of
// |a|^2, followed by a 24-stage second square root used by normalize and principal square
// root. Lower stages hold the multipliers (one per product), the sums and the sign-magnitude
// conversion. A one-word skid register at the output lets the pipeline take a word
// while a finished result waits; the pipeline stalls as a whole only while that
// register is occupied. Results are saturated to the component range, with the
// saturated flag raised, and a zero divisor, or a zero magnitude for normalize and
// inverse, gives a zero result with the div_zero flag raised.
module complex_arithmetic_unit #(
    parameter int WIDTH     = cau_pkg::CAU_WIDTH,
    parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // a_re, a_im, b_re, b_im from the lowest bit up, zero padded to whole bytes
    input  logic [((4*WIDTH+7)/8)*8-1:0]        s_tdata,
    // req_type
    input  logic [3:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // res_re, res_im from the lowest bit up, zero padded to whole bytes
    output logic [((2*WIDTH+7)/8)*8-1:0]        m_tdata,
    // div_zero, saturated from the lowest bit up
    output logic [1:0]                          m_tuser
);
    import cau_pkg::*;

    localparam int W    = WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int NW   = 2 * W + 2 * F;
    localparam int CW   = NW;
    localparam int QW   = (W + 1 > 2 * F + 1) ? W + 1 : 2 * F + 1;
    localparam int LX   = (W > QW + 1) ? W : QW + 1;
    localparam int SI0  = (W + F > 2 * F + 1) ? W + F : 2 * F + 1;
    localparam int SI   = SI0 + SI0 % 2;
    localparam int SR   = SI / 2;
    localparam int TDO  = ((2 * W + 7) / 8) * 8;

    localparam int S_PROD = 1;
    localparam int S_SUM  = 2;
    localparam int S_MAG  = 3;
    localparam int S_LOAD = 4;
    localparam int X0     = 5;
    localparam int Y0     = X0 + LX;
    localparam int Z0     = Y0 + 1;
    localparam int S_FIN  = Z0 + SR;
    localparam int NS     = S_FIN + 1;

    localparam int SM_MRE = 0;
    localparam int SM_MIM = 1;
    localparam int SM_NR  = 2;
    localparam int SM_NI  = 3;

    localparam logic [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [W-1:0] r_re;
        logic [W-1:0] r_im;
        logic         dz;
        logic         sat;
    } res_t;

    typedef struct packed {
        op_t                  op;
        logic [W-1:0]         a_re;
        logic [W-1:0]         a_im;
        logic [W-1:0]         b_re;
        logic [W-1:0]         b_im;
        logic                 an_re;
        logic                 an_im;
        logic [W-1:0]         am_re;
        logic [W-1:0]         am_im;
        logic [PW-1:0]        pr_aa_re;
        logic [PW-1:0]        pr_aa_im;
        logic [PW-1:0]        pr_bb_re;
        logic [PW-1:0]        pr_bb_im;
        logic [PW-1:0]        pr_rr;
        logic [PW-1:0]        pr_ii;
        logic [PW-1:0]        pr_ri;
        logic [PW-1:0]        pr_ir;
        logic [3:0][PW:0]     sum;
        logic [PW-1:0]        mag_sq;
        logic [PW-1:0]        den;
        logic [3:0]           sm_neg;
        logic [3:0][PW-1:0]   sm_mag;
        logic [PW-1:0]        dv_den;
        logic [1:0][NW-1:0]   dv_n;
        logic [1:0]           dv_neg;
        logic [1:0]           dv_ovf;
        logic [1:0][PW-1:0]   dv_rem;
        logic [1:0][QW-1:0]   dv_num;
        logic [1:0][QW-1:0]   dv_quo;
        logic [W:0]           s1_rem;
        logic [W-1:0]         s1_root;
        logic [PW-1:0]        s1_val;
        logic [1:0][SR:0]     s2_rem;
        logic [1:0][SR-1:0]   s2_root;
        logic [1:0][SI-1:0]   s2_val;
        logic [1:0]           s2_neg;
        res_t                 res;
    } stage_t;

    // Clamp a sign-magnitude value to the component range; bit W is the saturation flag.
    function automatic logic [W:0] clamp_mag(input logic neg, input logic [CW-1:0] mag,
                                             input logic huge);
        logic [CW-1:0] lim;
        logic          over;
        logic [W-1:0]  v;
        lim  = CW'(1) << (W - 1);
        over = huge || (neg ? (mag > lim) : (mag >= lim));
        if (over) begin
            v = neg ? S_MIN : S_MAX;
        end else begin
            v = neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
        end
        return {over, v};
    endfunction

    function automatic logic [W:0] clamp_s(input logic [W:0] s);
        logic [W:0] m;
        m = s[W] ? (~s + 1'b1) : s;
        return clamp_mag(s[W], CW'(m), 1'b0);
    endfunction

    stage_t        stg_reg [NS];
    stage_t        in_stg;
    logic [NS-1:0] vld_reg;
    logic          skid_full_reg;
    logic          skid_full_next;
    res_t          skid_reg;
    res_t          out_res;
    logic          en;

    assign en       = !skid_full_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    always_comb begin
        in_stg      = '0;
        in_stg.op   = op_t'(s_tuser);
        in_stg.a_re = s_tdata[W-1:0];
        in_stg.a_im = s_tdata[2*W-1:W];
        in_stg.b_re = s_tdata[3*W-1:2*W];
        in_stg.b_im = s_tdata[4*W-1:3*W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0] <= in_stg;
        end
    end

    for (genvar i = 1; i < NS; i++) begin : g_stage
        stage_t cur_stg;
        stage_t stg_next;

        assign cur_stg = stg_reg[i-1];

        if (i == S_PROD) begin : g_prod
            always_comb begin
                logic [W:0] ea_re, ea_im, eb_re, eb_im, t_re, t_im, c_re, c_im;
                logic       simple;
                stg_next          = cur_stg;
                stg_next.pr_aa_re = $signed(cur_stg.a_re) * $signed(cur_stg.a_re);
                stg_next.pr_aa_im = $signed(cur_stg.a_im) * $signed(cur_stg.a_im);
                stg_next.pr_bb_re = $signed(cur_stg.b_re) * $signed(cur_stg.b_re);
                stg_next.pr_bb_im = $signed(cur_stg.b_im) * $signed(cur_stg.b_im);
                stg_next.pr_rr    = $signed(cur_stg.a_re) * $signed(cur_stg.b_re);
                stg_next.pr_ii    = $signed(cur_stg.a_im) * $signed(cur_stg.b_im);
                stg_next.pr_ri    = $signed(cur_stg.a_re) * $signed(cur_stg.b_im);
                stg_next.pr_ir    = $signed(cur_stg.a_im) * $signed(cur_stg.b_re);
                stg_next.an_re    = cur_stg.a_re[W-1];
                stg_next.an_im    = cur_stg.a_im[W-1];
                stg_next.am_re    = cur_stg.a_re[W-1] ? (~cur_stg.a_re + 1'b1) : cur_stg.a_re;
                stg_next.am_im    = cur_stg.a_im[W-1] ? (~cur_stg.a_im + 1'b1) : cur_stg.a_im;
                stg_next.res      = '0;
                ea_re  = {cur_stg.a_re[W-1], cur_stg.a_re};
                ea_im  = {cur_stg.a_im[W-1], cur_stg.a_im};
                eb_re  = {cur_stg.b_re[W-1], cur_stg.b_re};
                eb_im  = {cur_stg.b_im[W-1], cur_stg.b_im};
                simple = 1'b1;
                t_re   = '0;
                t_im   = '0;
                case (cur_stg.op)
                    OP_ADD: begin
                        t_re = ea_re + eb_re;
                        t_im = ea_im + eb_im;
                    end
                    OP_SUB: begin
                        t_re = ea_re - eb_re;
                        t_im = ea_im - eb_im;
                    end
                    OP_NEG: begin
                        t_re = ~ea_re + 1'b1;
                        t_im = ~ea_im + 1'b1;
                    end
                    OP_CONJ: begin
                        t_re = ea_re;
                        t_im = ~ea_im + 1'b1;
                    end
                    default: begin
                        simple = 1'b0;
                    end
                endcase
                c_re = clamp_s(t_re);
                c_im = clamp_s(t_im);
                if (simple) begin
                    stg_next.res.r_re = c_re[W-1:0];
                    stg_next.res.r_im = c_im[W-1:0];
                    stg_next.res.sat  = c_re[W] | c_im[W];
                end
            end
        end else if (i == S_SUM) begin : g_sum
            always_comb begin
                logic [PW:0] e_rr, e_ii, e_ri, e_ir;
                stg_next = cur_stg;
                e_rr = {cur_stg.pr_rr[PW-1], cur_stg.pr_rr};
                e_ii = {cur_stg.pr_ii[PW-1], cur_stg.pr_ii};
                e_ri = {cur_stg.pr_ri[PW-1], cur_stg.pr_ri};
                e_ir = {cur_stg.pr_ir[PW-1], cur_stg.pr_ir};
                stg_next.sum[SM_MRE] = e_rr - e_ii;
                stg_next.sum[SM_MIM] = e_ri + e_ir;
                stg_next.sum[SM_NR]  = e_rr + e_ii;
                stg_next.sum[SM_NI]  = e_ir - e_ri;
                stg_next.mag_sq      = cur_stg.pr_aa_re + cur_stg.pr_aa_im;
                stg_next.den         = cur_stg.pr_bb_re + cur_stg.pr_bb_im;
            end
        end else if (i == S_MAG) begin : g_mag
            always_comb begin
                logic [PW:0] ng;
                stg_next = cur_stg;
                for (int k = 0; k < 4; k++) begin
                    ng = ~cur_stg.sum[k] + 1'b1;
                    stg_next.sm_neg[k] = cur_stg.sum[k][PW];
                    stg_next.sm_mag[k] = cur_stg.sum[k][PW] ? ng[PW-1:0]
                                                            : cur_stg.sum[k][PW-1:0];
                end
            end
        end else if (i == S_LOAD) begin : g_load
            always_comb begin
                logic [W:0] c_re, c_im;
                stg_next         = cur_stg;
                stg_next.s1_val  = cur_stg.mag_sq;
                stg_next.s1_rem  = '0;
                stg_next.s1_root = '0;
                stg_next.dv_den  = (cur_stg.op == OP_DIV) ? cur_stg.den : cur_stg.mag_sq;
                stg_next.dv_n    = '0;
                stg_next.dv_neg  = '0;
                c_re = '0;
                c_im = '0;
                case (cur_stg.op)
                    OP_MUL: begin
                        c_re = clamp_mag(cur_stg.sm_neg[SM_MRE],
                                         CW'(cur_stg.sm_mag[SM_MRE] >> F), 1'b0);
                        c_im = clamp_mag(cur_stg.sm_neg[SM_MIM],
                                         CW'(cur_stg.sm_mag[SM_MIM] >> F), 1'b0);
                        stg_next.res.r_re = c_re[W-1:0];
                        stg_next.res.r_im = c_im[W-1:0];
                        stg_next.res.sat  = c_re[W] | c_im[W];
                    end
                    OP_DOT: begin
                        c_re = clamp_mag(cur_stg.sm_neg[SM_NR],
                                         CW'(cur_stg.sm_mag[SM_NR] >> F), 1'b0);
                        stg_next.res.r_re = c_re[W-1:0];
                        stg_next.res.sat  = c_re[W];
                    end
                    OP_ABS2: begin
                        c_re = clamp_mag(1'b0, CW'(cur_stg.mag_sq >> F), 1'b0);
                        stg_next.res.r_re = c_re[W-1:0];
                        stg_next.res.sat  = c_re[W];
                    end
                    OP_DIV: begin
                        stg_next.dv_n[0]  = NW'(cur_stg.sm_mag[SM_NR]) << F;
                        stg_next.dv_n[1]  = NW'(cur_stg.sm_mag[SM_NI]) << F;
                        stg_next.dv_neg   = {cur_stg.sm_neg[SM_NI], cur_stg.sm_neg[SM_NR]};
                        stg_next.res.dz   = (cur_stg.den == '0);
                    end
                    OP_INV: begin
                        stg_next.dv_n[0]  = NW'(cur_stg.am_re) << (2 * F);
                        stg_next.dv_n[1]  = NW'(cur_stg.am_im) << (2 * F);
                        stg_next.dv_neg   = {!cur_stg.an_im, cur_stg.an_re};
                        stg_next.res.dz   = (cur_stg.mag_sq == '0);
                    end
                    OP_NORM: begin
                        stg_next.dv_n[0]  = NW'(cur_stg.pr_aa_re) << (2 * F);
                        stg_next.dv_n[1]  = NW'(cur_stg.pr_aa_im) << (2 * F);
                        stg_next.dv_neg   = {cur_stg.an_im, cur_stg.an_re};
                        stg_next.res.dz   = (cur_stg.mag_sq == '0);
                    end
                    default: begin
                    end
                endcase
            end
        end else if (i < Y0) begin : g_iter
            localparam int J = i - X0;
            always_comb begin
                logic [W+2:0] s1_t, s1_trial;
                logic [PW:0]  d_t;
                stg_next = cur_stg;
                // One root bit of |a|^2 per stage.
                if (J < W) begin
                    s1_t     = {cur_stg.s1_rem, cur_stg.s1_val[PW-1:PW-2]};
                    s1_trial = {1'b0, cur_stg.s1_root, 2'b01};
                    if (s1_t >= s1_trial) begin
                        stg_next.s1_rem  = (W+1)'(s1_t - s1_trial);
                        stg_next.s1_root = {cur_stg.s1_root[W-2:0], 1'b1};
                    end else begin
                        stg_next.s1_rem  = s1_t[W:0];
                        stg_next.s1_root = {cur_stg.s1_root[W-2:0], 1'b0};
                    end
                    stg_next.s1_val = cur_stg.s1_val << 2;
                end
                // The first stage checks for quotient overflow, the next ones each
                // produce one quotient bit.
                for (int l = 0; l < 2; l++) begin
                    if (J == 0) begin
                        stg_next.dv_ovf[l] = PW'(cur_stg.dv_n[l][NW-1:QW]) >= cur_stg.dv_den;
                        stg_next.dv_rem[l] = PW'(cur_stg.dv_n[l][NW-1:QW]);
                        stg_next.dv_num[l] = cur_stg.dv_n[l][QW-1:0];
                        stg_next.dv_quo[l] = '0;
                    end else if (J <= QW) begin
                        d_t = {cur_stg.dv_rem[l], cur_stg.dv_num[l][QW-1]};
                        if (d_t >= {1'b0, cur_stg.dv_den}) begin
                            stg_next.dv_rem[l] = PW'(d_t - {1'b0, cur_stg.dv_den});
                            stg_next.dv_quo[l] = {cur_stg.dv_quo[l][QW-2:0], 1'b1};
                        end else begin
                            stg_next.dv_rem[l] = d_t[PW-1:0];
                            stg_next.dv_quo[l] = {cur_stg.dv_quo[l][QW-2:0], 1'b0};
                        end
                        stg_next.dv_num[l] = cur_stg.dv_num[l] << 1;
                    end
                end
            end
        end else if (i == Y0) begin : g_mid
            always_comb begin
                logic [W+1:0] ea, p_sum, q_sum;
                logic [W:0]   c_re, c_im;
                stg_next         = cur_stg;
                stg_next.s2_rem  = '0;
                stg_next.s2_root = '0;
                stg_next.s2_val  = '0;
                stg_next.s2_neg  = '0;
                ea    = {{2{cur_stg.a_re[W-1]}}, cur_stg.a_re};
                p_sum = {2'b00, cur_stg.s1_root} + ea;
                q_sum = {2'b00, cur_stg.s1_root} - ea;
                c_re  = clamp_mag(cur_stg.dv_neg[0], CW'(cur_stg.dv_quo[0]), cur_stg.dv_ovf[0]);
                c_im  = clamp_mag(cur_stg.dv_neg[1], CW'(cur_stg.dv_quo[1]), cur_stg.dv_ovf[1]);
                case (cur_stg.op)
                    OP_ABS: begin
                        c_re = clamp_mag(1'b0, CW'(cur_stg.s1_root), 1'b0);
                        stg_next.res.r_re = c_re[W-1:0];
                        stg_next.res.sat  = c_re[W];
                    end
                    OP_DIV, OP_INV: begin
                        if (!cur_stg.res.dz) begin
                            stg_next.res.r_re = c_re[W-1:0];
                            stg_next.res.r_im = c_im[W-1:0];
                            stg_next.res.sat  = c_re[W] | c_im[W];
                        end
                    end
                    OP_NORM: begin
                        stg_next.s2_val[0] = SI'(cur_stg.dv_quo[0]);
                        stg_next.s2_val[1] = SI'(cur_stg.dv_quo[1]);
                        stg_next.s2_neg    = cur_stg.dv_neg;
                    end
                    OP_SQRT: begin
                        // |a| + x and |a| - x are never negative since |a| >= |x|.
                        stg_next.s2_val[0] = SI'(p_sum[W:0]) << (F - 1);
                        stg_next.s2_val[1] = SI'(q_sum[W:0]) << (F - 1);
                        stg_next.s2_neg    = {cur_stg.an_im, 1'b0};
                    end
                    default: begin
                    end
                endcase
            end
        end else if (i < S_FIN) begin : g_root
            always_comb begin
                logic [SR+2:0] t, trial;
                stg_next = cur_stg;
                for (int l = 0; l < 2; l++) begin
                    t     = {cur_stg.s2_rem[l], cur_stg.s2_val[l][SI-1:SI-2]};
                    trial = {1'b0, cur_stg.s2_root[l], 2'b01};
                    if (t >= trial) begin
                        stg_next.s2_rem[l]  = (SR+1)'(t - trial);
                        stg_next.s2_root[l] = {cur_stg.s2_root[l][SR-2:0], 1'b1};
                    end else begin
                        stg_next.s2_rem[l]  = t[SR:0];
                        stg_next.s2_root[l] = {cur_stg.s2_root[l][SR-2:0], 1'b0};
                    end
                    stg_next.s2_val[l] = cur_stg.s2_val[l] << 2;
                end
            end
        end else begin : g_fin
            always_comb begin
                logic [W:0] c_re, c_im;
                stg_next = cur_stg;
                c_re = clamp_mag(cur_stg.s2_neg[0], CW'(cur_stg.s2_root[0]), 1'b0);
                c_im = clamp_mag(cur_stg.s2_neg[1], CW'(cur_stg.s2_root[1]), 1'b0);
                if ((cur_stg.op == OP_NORM && !cur_stg.res.dz) || cur_stg.op == OP_SQRT) begin
                    stg_next.res.r_re = c_re[W-1:0];
                    stg_next.res.r_im = c_im[W-1:0];
                    stg_next.res.sat  = c_re[W] | c_im[W];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[i] <= stg_next;
            end
        end
    end

    // The skid register takes the oldest result when the sink stalls.
    always_comb begin
        skid_full_next = skid_full_reg;
        if (skid_full_reg) begin
            if (m_tready) begin
                skid_full_next = 1'b0;
            end
        end else if (vld_reg[NS-1] && !m_tready) begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_full_reg && vld_reg[NS-1] && !m_tready) begin
            skid_reg <= stg_reg[NS-1].res;
        end
    end

    assign out_res  = skid_full_reg ? skid_reg : stg_reg[NS-1].res;
    assign m_tvalid = skid_full_reg | vld_reg[NS-1];
    assign m_tdata  = TDO'({out_res.r_im, out_res.r_re});
    assign m_tuser  = {out_res.sat, out_res.dz};

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[2*W-1:0] == '0 && !m_tuser[1])
        else $error("zero divisor result is not zero");

    a_scalar_im: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NS-1] && (stg_reg[NS-1].op == OP_ABS2 || stg_reg[NS-1].op == OP_ABS ||
        stg_reg[NS-1].op == OP_DOT) |-> stg_reg[NS-1].res.r_im == '0)
        else $error("scalar result has a nonzero imaginary part");

    a_skid_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_full_reg) |-> $past(vld_reg[NS-1] && !m_tready))
        else $error("skid register filled without a stalled result");

    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg && !m_tready |=> skid_full_reg && $stable(skid_reg))
        else $error("held result changed during a stall");

endmodule

FILE: tb/cau_checker.sv
// Checker for the complex arithmetic unit: predicts each result word and compares it.
module cau_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [3:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    typedef logic signed [129:0] wide_t;
    typedef logic [129:0] uwide_t;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        div_zero;
        logic        saturated;
    } cplx_result_t;

    cplx_result_t expected_results[$];

    function automatic uwide_t mag(wide_t v);
        return (v < 0) ? uwide_t'(-v) : uwide_t'(v);
    endfunction

    function automatic uwide_t floor_root(uwide_t n);
        uwide_t r;
        uwide_t c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (uwide_t'(1) << i);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    // Drops the fraction bits, rounding toward zero.
    function automatic wide_t trunc_frac(wide_t v);
        return (v < 0) ? -wide_t'(mag(v) >> 16) : wide_t'(mag(v) >> 16);
    endfunction

    function automatic wide_t with_sign(logic neg, uwide_t m);
        return neg ? -wide_t'(m) : wide_t'(m);
    endfunction

    function automatic logic [31:0] clamp32(wide_t v, inout logic sat);
        if (v > wide_t'(32'sh7fffffff)) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -wide_t'(64'sh80000000)) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic cplx_result_t complex_result(logic [3:0] code, logic [127:0] d);
        wide_t ar, ai, br, bi, re, im, nr, ni, root_m;
        uwide_t sa, den;
        cplx_result_t r;
        logic sat;
        logic dz;
        ar = wide_t'($signed(d[31:0]));
        ai = wide_t'($signed(d[63:32]));
        br = wide_t'($signed(d[95:64]));
        bi = wide_t'($signed(d[127:96]));
        re = '0;
        im = '0;
        sat = 1'b0;
        dz = 1'b0;
        sa = uwide_t'(ar * ar + ai * ai);
        case (code)
            OP_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL: begin
                re = trunc_frac(ar * br - ai * bi);
                im = trunc_frac(ar * bi + ai * br);
            end
            OP_DIV: begin
                den = uwide_t'(br * br + bi * bi);
                if (den == 0) begin
                    dz = 1'b1;
                end else begin
                    nr = ar * br + ai * bi;
                    ni = ai * br - ar * bi;
                    re = with_sign(nr < 0, (mag(nr) << 16) / den);
                    im = with_sign(ni < 0, (mag(ni) << 16) / den);
                end
            end
            OP_NEG: begin
                re = -ar;
                im = -ai;
            end
            OP_CONJ: begin
                re = ar;
                im = -ai;
            end
            OP_ABS2: re = trunc_frac(wide_t'(sa));
            OP_ABS:  re = wide_t'(floor_root(sa));
            OP_NORM: begin
                if (sa == 0) begin
                    dz = 1'b1;
                end else begin
                    re = with_sign(ar < 0, floor_root((uwide_t'(ar * ar) << 32) / sa));
                    im = with_sign(ai < 0, floor_root((uwide_t'(ai * ai) << 32) / sa));
                end
            end
            OP_INV: begin
                if (sa == 0) begin
                    dz = 1'b1;
                end else begin
                    re = with_sign(ar < 0, (mag(ar) << 32) / sa);
                    im = with_sign(!(ai < 0), (mag(ai) << 32) / sa);
                end
            end
            OP_SQRT: begin
                // A zero imaginary part counts as positive.
                root_m = wide_t'(floor_root(sa));
                re = wide_t'(floor_root(mag(root_m + ar) << 15));
                im = with_sign(ai < 0, floor_root(mag(root_m - ar) << 15));
            end
            OP_DOT: re = trunc_frac(ar * br + ai * bi);
            default: ;
        endcase
        r.re = clamp32(re, sat);
        r.im = clamp32(im, sat);
        r.div_zero = dz;
        r.saturated = sat;
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        cplx_result_t want;
        if (!aresetn) begin
            errors = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(complex_result(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected word", m_tdata, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.re)
                        report("res_re", 64'(m_tdata[31:0]), 64'(want.re));
                    if (m_tdata[63:32] !== want.im)
                        report("res_im", 64'(m_tdata[63:32]), 64'(want.im));
                    if (m_tuser[0] !== want.div_zero)
                        report("div_zero", 64'(m_tuser[0]), 64'(want.div_zero));
                    if (m_tuser[1] !== want.saturated)
                        report("saturated", 64'(m_tuser[1]), 64'(want.saturated));
                end
            end
        end
    end
endmodule

FILE: tb/tb.sv
// Testbench top for the complex arithmetic unit: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_WORDS = 750;
    localparam logic [31:0] MAXV = 32'h7fffffff;
    localparam logic [31:0] MINV = 32'h80000000;
    localparam logic [31:0] ONE = 32'h00010000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           errors;
    int           pending;
    int           cycles;
    bit           quiet;
    int           out_stall;

    complex_arithmetic_unit u_dut (.*);

    cau_checker u_checker (.*);

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL complex_arithmetic_unit");
            $finish;
        end
    end

    // Result side backpressure in short random bursts.
    always @(negedge aclk) begin
        if (out_stall > 0) begin
            out_stall--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_stall = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Presents one word at a falling edge and holds it until it is taken.
    task automatic send_word(logic [3:0] code, logic [31:0] are, logic [31:0] aim,
                             logic [31:0] bre, logic [31:0] bim);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= code;
        s_tdata <= {bim, bre, aim, are};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3) == 0 ? MAXV : ($urandom_range(0, 1) ? MINV : 0);
            1, 2: return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [3:0] code;
        cycles = 0;
        quiet = 0;
        out_stall = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Extremes for every operation, then zero divisors, sign cases and unused codes.
        for (int op = OP_ADD; op <= OP_DOT; op++)
            send_word(4'(op), MAXV, MINV, MINV, MAXV);
        send_word(OP_DIV, ONE, MAXV, 0, 0);
        send_word(OP_NORM, 0, 0, ONE, ONE);
        send_word(OP_INV, 0, 0, 0, 0);
        send_word(OP_SQRT, 32'hfffc0000, 0, 0, 0);
        send_word(OP_SQRT, 32'h00030000, 32'hfffe0000, 0, 0);
        send_word(OP_INV, 32'h00000001, 32'hffffffff, 0, 0);
        send_word(OP_DIV, MAXV, MAXV, 32'h00000001, 0);
        for (int op = 12; op <= 15; op++)
            send_word(4'(op), MAXV, MINV, ONE, ONE);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) begin
                s_tvalid <= 1'b0;
                wait (pending == 0);
                @(negedge aclk);
            end
            quiet = (n > RANDOM_WORDS * 9 / 10);
            code = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                 : 4'($urandom_range(0, 11));
            send_word(code, operand(), operand(), operand(), operand());
        end
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS complex_arithmetic_unit");
        end else begin
            $display("FAIL complex_arithmetic_unit");
        end
        $finish;
    end
endmodule
